// ----- src/frsq_pkg.sv -----
// Package for the fast inverse square root unit: shared constants and the
// leading-zero count used by the floating-point stages. No dependencies.
package frsq_pkg;

    localparam logic [31:0] RSQRT_MAGIC   = 32'h5F3759DF;
    localparam logic [31:0] FP_ONE_HALF   = 32'h3F000000;
    localparam logic [31:0] FP_THREE_HALF = 32'h3FC00000;
    localparam logic [31:0] CANON_NAN     = 32'h7FC00000;
    localparam logic [7:0]  EXP_MAX       = 8'hFF;

    // Leading zeros of a 48-bit word; 48 when the word is zero.
    function automatic logic [5:0] lead_zeros(input logic [47:0] w);
        logic [5:0] n;
        logic       found;
        n     = 6'd48;
        found = 1'b0;
        for (int i = 47; i >= 0; i--)
        begin
            if (!found && w[i])
            begin
                n     = 6'(47 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ----- src/frsq_fmul.sv -----
// Three-stage single-precision multiplier, round to nearest even, with
// subnormal support. Uses frsq_pkg.
module frsq_fmul
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] p
);

    typedef struct packed {
        logic sign;
        logic nan;
        logic inf;
        logic zero;
    } mul_flags_t;

    // Stage 1: unpack, classify and multiply mantissas
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma, mb;
    logic [7:0]  xa, xb;
    mul_flags_t  m_flags_next;
    logic [47:0] m_prod_reg;
    logic signed [10:0] m_exp_reg;
    mul_flags_t  m_flags_reg;

    always_comb
    begin
        ea     = a[30:23];
        eb     = b[30:23];
        fa     = a[22:0];
        fb     = b[22:0];
        a_nan  = (ea == frsq_pkg::EXP_MAX) && (fa != 23'd0);
        b_nan  = (eb == frsq_pkg::EXP_MAX) && (fb != 23'd0);
        a_inf  = (ea == frsq_pkg::EXP_MAX) && (fa == 23'd0);
        b_inf  = (eb == frsq_pkg::EXP_MAX) && (fb == 23'd0);
        a_zero = (ea == 8'd0) && (fa == 23'd0);
        b_zero = (eb == 8'd0) && (fb == 23'd0);
        ma     = {ea != 8'd0, fa};
        mb     = {eb != 8'd0, fb};
        xa     = (ea == 8'd0) ? 8'd1 : ea;
        xb     = (eb == 8'd0) ? 8'd1 : eb;
        m_flags_next.sign = a[31] ^ b[31];
        m_flags_next.nan  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
        m_flags_next.inf  = a_inf | b_inf;
        m_flags_next.zero = a_zero | b_zero;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_prod_reg  <= ma * mb;
            m_exp_reg   <= $signed({3'd0, xa}) + $signed({3'd0, xb}) - 11'sd126;
            m_flags_reg <= m_flags_next;
        end
    end

    // Stage 2: normalize product so its top bit sits at bit 47
    logic [5:0]  lz;
    logic [47:0] n_prod_reg;
    logic signed [10:0] n_exp_reg;
    mul_flags_t  n_flags_reg;

    assign lz = frsq_pkg::lead_zeros(m_prod_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_prod_reg  <= m_prod_reg << lz;
            n_exp_reg   <= m_exp_reg - $signed({5'd0, lz});
            n_flags_reg <= m_flags_reg;
        end
    end

    // Stage 3: denormalize if needed, round, pick special results
    logic signed [10:0] sh_wide;
    logic [5:0]  sh;
    logic [47:0] shifted, lost_mask;
    logic        lost, rb, st, inc, ovf;
    logic [23:0] kept;
    logic [7:0]  eenc;
    logic [30:0] rounded;
    logic [31:0] p_next;
    logic [31:0] p_reg;

    always_comb
    begin
        sh_wide   = 11'sd1 - n_exp_reg;
        if (n_exp_reg >= 11'sd1)
            sh = 6'd0;
        else if (sh_wide > 11'sd48)
            sh = 6'd48;
        else
            sh = sh_wide[5:0];
        shifted   = n_prod_reg >> sh;
        lost_mask = (48'd1 << sh) - 48'd1;
        lost      = |(n_prod_reg & lost_mask);
        kept      = shifted[47:24];
        rb        = shifted[23];
        st        = (|shifted[22:0]) | lost;
        inc       = rb & (st | kept[0]);
        eenc      = (n_exp_reg >= 11'sd1) ? n_exp_reg[7:0] : 8'd0;
        ovf       = n_exp_reg >= 11'sd255;
        rounded   = {eenc, kept[22:0]} + {30'd0, inc};
        if (n_flags_reg.nan)
            p_next = frsq_pkg::CANON_NAN;
        else if (n_flags_reg.inf || ovf)
            p_next = {n_flags_reg.sign, frsq_pkg::EXP_MAX, 23'd0};
        else if (n_flags_reg.zero)
            p_next = {n_flags_reg.sign, 31'd0};
        else
            p_next = {n_flags_reg.sign, rounded};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// ----- src/frsq_fadd.sv -----
// Three-stage single-precision adder, round to nearest even, with
// subnormal support. Uses frsq_pkg.
module frsq_fadd
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] s
);

    typedef struct packed {
        logic sub;
        logic sign;
        logic zero_sign;
        logic nan;
        logic inf;
        logic inf_sign;
    } add_flags_t;

    // Stage 1: order by magnitude and align the smaller operand
    logic [31:0] big, sml;
    logic [7:0]  ea, eb, xbig, xsml, d;
    logic        a_nan, b_nan, a_inf, b_inf;
    logic [26:0] mbig, msml, msh, mask;
    logic [4:0]  amt;
    add_flags_t  a_flags_next;
    logic [26:0] a_big_reg, a_sml_reg;
    logic [7:0]  a_exp_reg;
    add_flags_t  a_flags_reg;

    always_comb
    begin
        ea    = a[30:23];
        eb    = b[30:23];
        a_nan = (ea == frsq_pkg::EXP_MAX) && (a[22:0] != 23'd0);
        b_nan = (eb == frsq_pkg::EXP_MAX) && (b[22:0] != 23'd0);
        a_inf = (ea == frsq_pkg::EXP_MAX) && (a[22:0] == 23'd0);
        b_inf = (eb == frsq_pkg::EXP_MAX) && (b[22:0] == 23'd0);
        if (b[30:0] > a[30:0])
        begin
            big = b;
            sml = a;
        end
        else
        begin
            big = a;
            sml = b;
        end
        xbig = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        xsml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mbig = {big[30:23] != 8'd0, big[22:0], 3'd0};
        msml = {sml[30:23] != 8'd0, sml[22:0], 3'd0};
        d    = xbig - xsml;
        amt  = (d > 8'd27) ? 5'd27 : d[4:0];
        msh  = msml >> amt;
        mask = (27'd1 << amt) - 27'd1;
        a_flags_next.sub       = a[31] ^ b[31];
        a_flags_next.sign      = big[31];
        a_flags_next.zero_sign = a[31] & b[31];
        a_flags_next.nan       = a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
        a_flags_next.inf       = a_inf | b_inf;
        a_flags_next.inf_sign  = a_inf ? a[31] : b[31];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_big_reg   <= mbig;
            a_sml_reg   <= {msh[26:1], msh[0] | (|(msml & mask))};
            a_exp_reg   <= xbig;
            a_flags_reg <= a_flags_next;
        end
    end

    // Stage 2: add or subtract aligned mantissas
    logic [27:0] b_sum_reg;
    logic [7:0]  b_exp_reg;
    add_flags_t  b_flags_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (a_flags_reg.sub)
                b_sum_reg <= {1'b0, a_big_reg} - {1'b0, a_sml_reg};
            else
                b_sum_reg <= {1'b0, a_big_reg} + {1'b0, a_sml_reg};
            b_exp_reg   <= a_exp_reg;
            b_flags_reg <= a_flags_reg;
        end
    end

    // Stage 3: normalize, round, pick special results
    logic [5:0]  lz;
    logic [7:0]  shl;
    logic [26:0] norm;
    logic [8:0]  e;
    logic [7:0]  eenc;
    logic        inc;
    logic [30:0] rounded;
    logic [31:0] s_next;
    logic [31:0] s_reg;

    always_comb
    begin
        lz  = frsq_pkg::lead_zeros({b_sum_reg[26:0], 21'd0});
        shl = ({2'd0, lz} < b_exp_reg) ? {2'd0, lz} : (b_exp_reg - 8'd1);
        if (b_sum_reg[27])
        begin
            norm = {b_sum_reg[27:2], b_sum_reg[1] | b_sum_reg[0]};
            e    = {1'b0, b_exp_reg} + 9'd1;
        end
        else
        begin
            norm = b_sum_reg[26:0] << shl;
            e    = {1'b0, b_exp_reg} - {1'b0, shl};
        end
        eenc    = norm[26] ? e[7:0] : 8'd0;
        inc     = norm[2] & (norm[1] | norm[0] | norm[3]);
        rounded = {eenc, norm[25:3]} + {30'd0, inc};
        if (b_flags_reg.nan)
            s_next = frsq_pkg::CANON_NAN;
        else if (b_flags_reg.inf)
            s_next = {b_flags_reg.inf_sign, frsq_pkg::EXP_MAX, 23'd0};
        else if (b_sum_reg == 28'd0)
            s_next = {b_flags_reg.zero_sign, 31'd0};
        else if (e >= 9'd255)
            s_next = {b_flags_reg.sign, frsq_pkg::EXP_MAX, 23'd0};
        else
            s_next = {b_flags_reg.sign, rounded};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s_reg <= s_next;
    end

    assign s = s_reg;

endmodule

// ----- src/fast_inverse_square_root_unit.sv -----
// Top level of the fast inverse square root unit: integer guess plus one
// Newton step. Uses frsq_pkg, frsq_fmul and frsq_fadd.
//
// Usage:
//   s_axis: one IEEE-754 single word per transfer (s_tdata).
//   m_axis: one IEEE-754 single word per transfer (m_tdata), the
//   approximate 1/sqrt(x); NaN results come out as 0x7FC00000.
//   From input transfer to output valid a word passes five floating-point
//   units (0.5*x, half*y, t*y, 1.5-t, y*r) of three register stages each,
//   in series. Throughput is one transfer per cycle unless the receiver
//   stalls; each unit stage takes a new word every cycle while not stalled,
//   and the first-guess subtract feeds the guess delay line.
//   When the receiver stalls with a result waiting, the whole pipeline
//   freezes and s_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits; data registers are not reset.
module fast_inverse_square_root_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] recip_root_bits
);

    localparam int Depth   = 15;
    localparam int YDepth  = 12;

    logic             en;
    logic [Depth-1:0] vld_reg;
    logic [31:0]      y_reg [YDepth];
    logic [31:0]      guess;
    logic [31:0]      half, t1, t, r, y_out;

    assign en       = !vld_reg[Depth-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[Depth-1];
    assign m_tdata  = y_out;

    // First guess from the integer trick
    assign guess = frsq_pkg::RSQRT_MAGIC - {s_tdata[31], s_tdata[31:1]};

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[Depth-2:0], s_tvalid};
    end

    // Guess delay line alongside the first four units
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg[0] <= guess;
            for (int i = 1; i < YDepth; i++)
                y_reg[i] <= y_reg[i-1];
        end
    end

    // Newton step
    frsq_fmul u_half (.clk(clk), .en(en), .a(frsq_pkg::FP_ONE_HALF), .b(s_tdata), .p(half));
    frsq_fmul u_t1   (.clk(clk), .en(en), .a(half), .b(y_reg[2]), .p(t1));
    frsq_fmul u_t    (.clk(clk), .en(en), .a(t1), .b(y_reg[5]), .p(t));
    frsq_fadd u_r    (.clk(clk), .en(en), .a(frsq_pkg::FP_THREE_HALF),
                      .b({~t[31], t[30:0]}), .s(r));
    frsq_fmul u_y    (.clk(clk), .en(en), .a(y_reg[YDepth-1]), .b(r), .p(y_out));

    // Checks
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted word did not enter the pipeline");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");

    a_nan_canonical: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[30:23] == frsq_pkg::EXP_MAX) && (m_tdata[22:0] != 23'd0))
        |-> (m_tdata == frsq_pkg::CANON_NAN))
        else $error("non-canonical NaN on output");

endmodule
